// ----- hw/rtl/nffa_pkg.sv -----
package nffa_pkg;

    // Defaults for the top-level parameters.
    localparam int ARENA_UNITS_DEF = 4096;
    localparam int UNIT_BYTES_DEF  = 16;

    // Fixed field widths of the command and result ports.
    localparam int ADDR_BITS = 12;
    localparam int BYTE_BITS = 16;

    // Dividend of the unit rounding: request bytes plus (unit size - 1).
    localparam int DIV_BITS  = BYTE_BITS + 1;
    // Units needed, including the header unit.
    localparam int NEED_BITS = DIV_BITS + 1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_A_PREV,
        S_A_CUR,
        S_A_CARVE,
        S_F_BP,
        S_F_WALK,
        S_F_Q,
        S_F_P
    } t_state;

endpackage

// ----- hw/rtl/next_fit_free_list_allocator.sv -----
// Next-fit free-list allocator over an arena of ARENA_UNITS header units.
// Commands: raise start with opcode, request_bytes and block_address; the
// transaction is taken at a clock edge where start is high and busy is low.
// An allocate returns the data unit address of a block of
// ceil(bytes / UNIT_BYTES) + 1 units, carved from the tail of the first
// free block that fits, searching from the rover. A free returns the block
// to the address-ordered list and merges it with its neighbors.
// Each transaction yields one result, shown for exactly one cycle with
// o_done high; the receiver cannot stall, so no result is ever held back.
// Sequence: an allocate rounds to units, reads the rover, examines the
// free-list headers one by one and presents the result, with a carve step
// added for a split. A free reads the block header, walks the headers up to
// its insertion point and writes the block and predecessor headers; a free
// with a bad address answers straight from idle, one with a bad block size
// after the header read. Every list step is one read of the header memory.
// busy drops in the result cycle, so the next command can be taken at the
// edge that ends it.
// Reset: the header memory is cleared address by address, leaving the
// sentinel and one free block spanning the rest of the arena; busy is high
// during that pass.
module next_fit_free_list_allocator #(
    parameter int ARENA_UNITS = nffa_pkg::ARENA_UNITS_DEF,
    parameter int UNIT_BYTES  = nffa_pkg::UNIT_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic [nffa_pkg::BYTE_BITS-1:0] i_request_bytes,
    input  logic [nffa_pkg::ADDR_BITS-1:0] i_block_address,
    output logic                           o_done,
    output logic                           o_granted,
    output logic [nffa_pkg::ADDR_BITS-1:0] o_data_address
);
    import nffa_pkg::*;

    localparam int AW     = $clog2(ARENA_UNITS);
    localparam int SW     = AW + 1;
    localparam int DW     = AW + SW;
    localparam int CW     = (SW > NEED_BITS) ? SW : NEED_BITS;
    localparam int XW     = AW + 2;
    localparam int STEP_W = $clog2(ARENA_UNITS + 2) + 1;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_rover, n_rover;
    logic [AW-1:0]      r_p, n_p;
    logic [SW-1:0]      r_p_size, n_p_size;
    logic [AW-1:0]      r_c, n_c;
    logic [AW-1:0]      r_bp, n_bp;
    logic [AW-1:0]      r_bp_link, n_bp_link;
    logic [SW-1:0]      r_bp_size, n_bp_size;
    logic [CW-1:0]      r_need, n_need;
    logic [STEP_W-1:0]  r_steps, n_steps;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_done, n_done;
    logic               r_granted, n_granted;
    logic [ADDR_BITS-1:0] r_addr, n_addr;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [DW-1:0]      wdata;
    logic [AW-1:0]      raddr;
    logic [DW-1:0]      rdata;
    logic [AW-1:0]      rd_link;
    logic [SW-1:0]      rd_size;

    logic               div_start;
    logic               div_done;
    logic [NEED_BITS-1:0] div_need;

    logic [31:0]        free_hdr;
    logic [SW-1:0]      split_size;
    logic [XW-1:0]      bp_end;
    logic [XW-1:0]      p_end;
    logic               walk_inside;
    logic               walk_wrap;

    nffa_ram #(
        .DEPTH (ARENA_UNITS),
        .AW    (AW),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    nffa_div #(
        .UNIT_BYTES (UNIT_BYTES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_bytes (i_request_bytes),
        .o_done  (div_done),
        .o_need  (div_need)
    );

    assign rd_link = rdata[DW-1:SW];
    assign rd_size = rdata[SW-1:0];

    assign free_hdr   = 32'(i_block_address) - 32'd1;
    assign split_size = rd_size - r_need[SW-1:0];
    assign bp_end     = XW'(r_bp) + XW'(r_bp_size);
    assign p_end      = XW'(r_p) + XW'(r_p_size);

    // Insertion point: bp sits strictly between p and its successor, or p is
    // the highest free block and bp lies past it or below the lowest.
    assign walk_inside = (r_bp > r_p) && (r_bp < rd_link);
    assign walk_wrap   = (r_p >= rd_link) && ((r_bp > r_p) || (r_bp < rd_link));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_rover   <= '0;
            r_clr     <= '0;
            r_done    <= 1'b0;
            r_granted <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_rover   <= n_rover;
            r_clr     <= n_clr;
            r_done    <= n_done;
            r_granted <= n_granted;
            r_addr    <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_p_size  <= n_p_size;
        r_c       <= n_c;
        r_bp      <= n_bp;
        r_bp_link <= n_bp_link;
        r_bp_size <= n_bp_size;
        r_need    <= n_need;
        r_steps   <= n_steps;
    end

    always_comb begin
        n_state   = r_state;
        n_rover   = r_rover;
        n_p       = r_p;
        n_p_size  = r_p_size;
        n_c       = r_c;
        n_bp      = r_bp;
        n_bp_link = r_bp_link;
        n_bp_size = r_bp_size;
        n_need    = r_need;
        n_steps   = r_steps;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_granted = r_granted;
        n_addr    = r_addr;
        we        = 1'b0;
        waddr     = '0;
        wdata     = '0;
        raddr     = '0;
        div_start = 1'b0;

        unique case (r_state)
            S_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                if (r_clr == AW'(0)) begin
                    wdata = {AW'(1), SW'(0)};
                end else if (r_clr == AW'(1)) begin
                    wdata = {AW'(0), SW'(ARENA_UNITS - 1)};
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(ARENA_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                raddr = AW'(free_hdr);
                if (start) begin
                    if (i_opcode == OP_ALLOC) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else if (i_block_address < ADDR_BITS'(2) ||
                                 free_hdr >= 32'(ARENA_UNITS)) begin
                        n_done    = 1'b1;
                        n_granted = 1'b0;
                        n_addr    = '0;
                    end else begin
                        n_bp    = AW'(free_hdr);
                        n_state = S_F_BP;
                    end
                end
            end

            S_DIV: begin
                raddr = r_rover;
                if (div_done) begin
                    n_need  = CW'(div_need);
                    n_p     = r_rover;
                    n_steps = '0;
                    n_state = S_A_PREV;
                end
            end

            S_A_PREV: begin
                n_p_size = rd_size;
                n_c      = rd_link;
                raddr    = rd_link;
                n_state  = S_A_CUR;
            end

            S_A_CUR: begin
                if (CW'(rd_size) >= r_need) begin
                    n_rover = r_p;
                    we      = 1'b1;
                    if (CW'(rd_size) == r_need) begin
                        // Exact fit: unlink the block from its predecessor.
                        waddr     = r_p;
                        wdata     = {rd_link, r_p_size};
                        n_done    = 1'b1;
                        n_granted = 1'b1;
                        n_addr    = ADDR_BITS'(32'(r_c) + 32'd1);
                        n_state   = S_IDLE;
                    end else begin
                        // Shrink the block and fetch the header of its tail.
                        waddr   = r_c;
                        wdata   = {rd_link, split_size};
                        n_c     = r_c + split_size[AW-1:0];
                        raddr   = r_c + split_size[AW-1:0];
                        n_state = S_A_CARVE;
                    end
                end else if (r_c == r_rover ||
                             r_steps >= STEP_W'(ARENA_UNITS + 1)) begin
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_addr    = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_steps  = r_steps + 1'b1;
                    n_p      = r_c;
                    n_p_size = rd_size;
                    n_c      = rd_link;
                    raddr    = rd_link;
                end
            end

            S_A_CARVE: begin
                we        = 1'b1;
                waddr     = r_c;
                wdata     = {rd_link, r_need[SW-1:0]};
                n_done    = 1'b1;
                n_granted = 1'b1;
                n_addr    = ADDR_BITS'(32'(r_c) + 32'd1);
                n_state   = S_IDLE;
            end

            S_F_BP: begin
                raddr = r_rover;
                if (rd_size == SW'(0) ||
                    32'(rd_size) > 32'(ARENA_UNITS) - 32'(r_bp)) begin
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_addr    = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_bp_size = rd_size;
                    n_p       = r_rover;
                    n_steps   = '0;
                    n_state   = S_F_WALK;
                end
            end

            S_F_WALK: begin
                raddr = rd_link;
                if (walk_inside || walk_wrap) begin
                    n_p_size = rd_size;
                    n_c      = rd_link;
                    n_state  = S_F_Q;
                end else if (r_steps >= STEP_W'(ARENA_UNITS + 1)) begin
                    n_done    = 1'b1;
                    n_granted = 1'b0;
                    n_addr    = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_steps = r_steps + 1'b1;
                    n_p     = rd_link;
                end
            end

            S_F_Q: begin
                we    = 1'b1;
                waddr = r_bp;
                if (bp_end == XW'(r_c)) begin
                    n_bp_link = rd_link;
                    n_bp_size = r_bp_size + rd_size;
                end else begin
                    n_bp_link = r_c;
                end
                wdata   = {n_bp_link, n_bp_size};
                n_state = S_F_P;
            end

            S_F_P: begin
                we    = 1'b1;
                waddr = r_p;
                if (p_end == XW'(r_bp)) begin
                    wdata = {r_bp_link, r_p_size + r_bp_size};
                end else begin
                    wdata = {r_bp, r_p_size};
                end
                n_rover   = r_p;
                n_done    = 1'b1;
                n_granted = 1'b1;
                n_addr    = '0;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = r_state != S_IDLE;
    assign o_done         = r_done;
    assign o_granted      = r_granted;
    assign o_data_address = r_addr;

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_granted |-> o_data_address == '0)
        else $error("refused transaction returned a nonzero address");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_done)
        else $error("result issued during the arena clear pass");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the rounding state");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted transaction neither started nor answered");

endmodule

// ----- hw/rtl/nffa_ram.sv -----
module nffa_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 25
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/nffa_div.sv -----
module nffa_div #(
    parameter int UNIT_BYTES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [nffa_pkg::BYTE_BITS-1:0] i_bytes,
    output logic                          o_done,
    output logic [nffa_pkg::NEED_BITS-1:0] o_need
);
    import nffa_pkg::*;

    localparam int LW = $clog2(UNIT_BYTES);
    localparam int SH = DIV_BITS + LW;
    localparam int MW = DIV_BITS + 2;
    localparam int PW = DIV_BITS + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(UNIT_BYTES) - 64'd1) / 64'(UNIT_BYTES));

    // Rounding to whole units by a reciprocal multiply. With the shift set to
    // the dividend width plus the bits of the unit size, the quotient is exact
    // for every dividend that fits in DIV_BITS.
    logic [DIV_BITS-1:0]  dividend;
    logic [PW-1:0]        product;
    logic [NEED_BITS-1:0] r_need;
    logic                 r_done;

    assign dividend = DIV_BITS'(i_bytes) + DIV_BITS'(UNIT_BYTES - 1);
    assign product  = PW'(dividend) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_need <= NEED_BITS'(product[PW-1:SH]) + NEED_BITS'(1);
        end
    end

    assign o_done = r_done;
    assign o_need = r_need;

endmodule

// ----- test/tb_next_fit_free_list_allocator.sv -----
`timescale 1ns / 100ps

module tb_next_fit_free_list_allocator;
    import nffa_pkg::*;

    localparam int UNITS   = 4096;
    localparam int UBYTES  = 16;
    localparam int N_ITEMS = 1450;

    typedef struct {
        t_opcode     op;
        logic [15:0] bytes;
        logic [11:0] addr;
        bit          typed;
        logic        g;
        logic [11:0] a;
    } t_row;

    typedef struct {
        logic        g;
        logic [11:0] a;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [15:0] i_request_bytes;
    logic [11:0] i_block_address;
    logic        o_done;
    logic        o_granted;
    logic [11:0] o_data_address;

    // Shadow copy of the header memory and the rover.
    int unsigned hdr_link [UNITS];
    int unsigned hdr_size [UNITS];
    int unsigned rover_q;

    t_grant      pending_grants[$];
    logic [11:0] live_blocks[$];
    int          n_errors;

    next_fit_free_list_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .o_done          (o_done),
        .o_granted       (o_granted),
        .o_data_address  (o_data_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    function automatic bit alloc_units(input int unsigned bytes, output int unsigned addr);
        int unsigned need;
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        need  = (bytes + UBYTES - 1) / UBYTES + 1;
        prev  = rover_q;
        cur   = hdr_link[prev];
        steps = 0;
        addr  = 0;
        forever begin
            if (hdr_size[cur] >= need) begin
                if (hdr_size[cur] == need) begin
                    hdr_link[prev] = hdr_link[cur];
                end else begin
                    hdr_size[cur] -= need;
                    cur += hdr_size[cur];
                    hdr_size[cur] = need;
                end
                rover_q = prev;
                addr = cur + 1;
                return 1'b1;
            end
            if (cur == rover_q) return 1'b0;
            steps++;
            if (steps > UNITS + 1) return 1'b0;
            prev = cur;
            cur  = hdr_link[cur];
        end
    endfunction

    function automatic bit release_block(input int unsigned addr);
        int unsigned bp;
        int unsigned p;
        int unsigned q;
        int unsigned steps;
        steps = 0;
        if (addr < 2 || addr - 1 >= UNITS) return 1'b0;
        bp = addr - 1;
        if (hdr_size[bp] == 0 || hdr_size[bp] > UNITS - bp) return 1'b0;
        p = rover_q;
        while (!(bp > p && bp < hdr_link[p])) begin
            if (p >= hdr_link[p] && (bp > p || bp < hdr_link[p])) break;
            steps++;
            if (steps > UNITS + 1) return 1'b0;
            p = hdr_link[p];
        end
        q = hdr_link[p];
        if (bp + hdr_size[bp] == q) begin
            hdr_size[bp] += hdr_size[q];
            hdr_link[bp] = hdr_link[q];
        end else begin
            hdr_link[bp] = q;
        end
        if (p + hdr_size[p] == bp) begin
            hdr_size[p] += hdr_size[bp];
            hdr_link[p] = hdr_link[bp];
        end else begin
            hdr_link[p] = bp;
        end
        rover_q = p;
        return 1'b1;
    endfunction

    // Drives one command, waits for it to be taken, then records the expected grant.
    task automatic issue_cmd(input t_opcode op, input logic [15:0] bytes,
                             input logic [11:0] addr, output t_grant res);
        int unsigned gap;
        int unsigned got;
        int          idx[$];
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_opcode        <= op;
        i_request_bytes <= bytes;
        i_block_address <= addr;
        do @(posedge i_clk); while (busy);
        if (op == OP_ALLOC) begin
            res.g = alloc_units(bytes, got);
            res.a = res.g ? got[11:0] : 12'd0;
            if (res.g) live_blocks.push_back(got[11:0]);
        end else begin
            res.g = release_block(addr);
            res.a = 12'd0;
            idx = live_blocks.find_first_index(x) with (x == addr);
            if (res.g && idx.size() > 0) live_blocks.delete(idx[0]);
        end
        pending_grants.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_done) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected transaction, granted", o_granted, -1);
            end else begin
                want = pending_grants.pop_front();
                if (o_granted !== want.g) report_mismatch("granted", o_granted, want.g);
                if (o_data_address !== want.a)
                    report_mismatch("data_address", o_data_address, want.a);
            end
        end
    end

    t_row directed[] = '{
        '{OP_ALLOC, 16'd0,     12'd0,    1, 1'b1, 12'd0},
        '{OP_ALLOC, 16'hFFFF,  12'd0,    1, 1'b0, 12'd0},
        '{OP_FREE,  16'hFFFF,  12'd0,    1, 1'b0, 12'd0},
        '{OP_FREE,  16'd0,     12'd1,    1, 1'b0, 12'd0},
        '{OP_FREE,  16'd0,     12'hFFF,  1, 1'b0, 12'd0},
        '{OP_FREE,  16'd0,     12'd2000, 1, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd64000, 12'hFFF,  0, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd16,    12'd0,    0, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd100,   12'd0,    0, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd1,     12'd0,    0, 1'b0, 12'd0},
        '{OP_FREE,  16'd0,     12'd4094, 0, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd16,    12'd0,    0, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd17,    12'd0,    0, 1'b0, 12'd0},
        '{OP_FREE,  16'd0,     12'd4094, 0, 1'b0, 12'd0},
        '{OP_FREE,  16'd0,     12'd4092, 0, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd32000, 12'd0,    0, 1'b0, 12'd0},
        '{OP_ALLOC, 16'd40000, 12'd0,    0, 1'b0, 12'd0}
    };

    initial begin
        t_grant      res;
        t_opcode     op;
        logic [15:0] bytes;
        logic [11:0] addr;
        int          pick;
        int          waited;
        n_errors        = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = OP_ALLOC;
        i_request_bytes = '0;
        i_block_address = '0;
        for (int u = 0; u < UNITS; u++) begin
            hdr_link[u] = 0;
            hdr_size[u] = 0;
        end
        hdr_link[0] = 1;
        hdr_size[1] = UNITS - 1;
        rover_q     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            issue_cmd(directed[k].op, directed[k].bytes, directed[k].addr, res);
            if (directed[k].typed && (res.g !== directed[k].g || res.a !== directed[k].a))
                report_mismatch("table row", k, -1);
        end
        live_blocks.delete();

        // Mostly matched allocate and free pairs; a few stray commands with raw fields.
        for (int n = 0; n < N_ITEMS; n++) begin
            pick  = $urandom_range(0, 99);
            bytes = 16'($urandom_range(0, 200));
            addr  = 12'($urandom());
            if (pick < 6) begin
                op    = t_opcode'($urandom_range(0, 1));
                bytes = 16'($urandom());
            end else if (pick < 50 && live_blocks.size() > 0) begin
                op   = OP_FREE;
                addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            end else begin
                op = OP_ALLOC;
                if (pick > 96) bytes = 16'($urandom());
                else if (pick > 85) bytes = 16'($urandom_range(0, 8000));
            end
            issue_cmd(op, bytes, addr, res);
        end
        start <= 1'b0;

        waited = 0;
        while (pending_grants.size() > 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && pending_grants.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
